// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high.
`define TPA_ASSERT_SAME(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while dis is high.
`define TPA_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/tpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Triangle primitive assembler package
// Coordinate types, mode and command codes, and the op word passed from the
// front end to the back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tpa_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int IO_WIDTH    = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [IO_WIDTH-1:0]    io_coord_t;
  typedef logic [1:0]                    count_t;

  typedef enum logic [1:0] {
    MODE_TRIANGLES = 2'd0,
    MODE_STRIP     = 2'd1,
    MODE_FAN       = 2'd2,
    MODE_UNKNOWN   = 2'd3
  } mode_t;

  typedef enum logic {
    CMD_BEGIN  = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    OP_HOLD0      = 3'd0,
    OP_HOLD1      = 3'd1,
    OP_EMIT_TRI   = 3'd2,
    OP_EMIT_STRIP = 3'd3,
    OP_EMIT_FAN   = 3'd4
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    coord_t   x;
    coord_t   y;
  } op_t;

  // Sign-extend or truncate an input word to the held coordinate width.
  function automatic coord_t to_coord(io_coord_t v);
    return coord_t'(v);
  endfunction

  // Sign-extend or truncate a held coordinate to the output word width.
  function automatic io_coord_t to_io(coord_t v);
    return io_coord_t'(v);
  endfunction

endpackage

// ===== rtl/tpa_front.sv =====
// ---------------------------------------------------------------------------
// Triangle assembler front end
// Tracks primitive mode and held-vertex count, and turns each input word into
// an op for the back end, or drops it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa_front import tpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_command,
  input  logic [1:0] in_prim_mode,
  input  io_coord_t in_vert_x,
  input  io_coord_t in_vert_y,
  input  logic      q_full,
  output logic      push,
  output op_t       push_op
);

  mode_t  mode_r,  mode_nxt;
  count_t count_r, count_nxt;
  logic   accept;
  logic   emit_op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    mode_nxt     = mode_r;
    count_nxt    = count_r;
    emit_op      = 1'b0;
    push_op.kind = OP_HOLD0;
    push_op.x    = to_coord(in_vert_x);
    push_op.y    = to_coord(in_vert_y);
    if (cmd_t'(in_command) == CMD_BEGIN) begin
      mode_nxt  = mode_t'(in_prim_mode);
      count_nxt = 2'd0;
    end else begin
      case (mode_r)
        MODE_STRIP, MODE_FAN: begin
          emit_op = 1'b1;
          if (count_r == 2'd0) begin
            push_op.kind = OP_HOLD0;
            count_nxt    = 2'd1;
          end else if (count_r == 2'd1) begin
            push_op.kind = OP_HOLD1;
            count_nxt    = 2'd2;
          end else if (mode_r == MODE_STRIP) begin
            push_op.kind = OP_EMIT_STRIP;
          end else begin
            push_op.kind = OP_EMIT_FAN;
          end
        end
        MODE_TRIANGLES: begin
          emit_op = 1'b1;
          if (count_r == 2'd0) begin
            push_op.kind = OP_HOLD0;
            count_nxt    = 2'd1;
          end else if (count_r == 2'd1) begin
            push_op.kind = OP_HOLD1;
            count_nxt    = 2'd2;
          end else begin
            push_op.kind = OP_EMIT_TRI;
            count_nxt    = 2'd0;
          end
        end
        default: begin
          emit_op = 1'b0;
        end
      endcase
    end
  end

  assign push = accept && emit_op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_UNKNOWN;
      count_r <= 2'd0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/tpa_queue.sv =====
// ---------------------------------------------------------------------------
// Triangle assembler op queue
// Short FIFO of op words between front and back end; push and pop may
// happen in the same cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa_queue import tpa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t               slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ===== rtl/tpa_back.sv =====
// ---------------------------------------------------------------------------
// Triangle assembler back end
// Holds the two carried vertices, executes ops and keeps the registered
// triangle output word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa_back import tpa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  op_t       head_op,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output io_coord_t out_first_x,
  output io_coord_t out_first_y,
  output io_coord_t out_second_x,
  output io_coord_t out_second_y,
  output io_coord_t out_third_x,
  output io_coord_t out_third_y
);

  coord_t    h0x_r, h0y_r, h1x_r, h1y_r;
  io_coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic      valid_r, valid_nxt;
  logic      is_emit;
  logic      slot_free;

  assign is_emit   = (head_op.kind == OP_EMIT_TRI) || (head_op.kind == OP_EMIT_STRIP) ||
                     (head_op.kind == OP_EMIT_FAN);
  assign slot_free = !valid_r || !out_stall;
  assign pop       = head_valid && (!is_emit || slot_free);

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
    if (pop && is_emit) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (head_op.kind)
        OP_HOLD0: begin
          h0x_r <= head_op.x;
          h0y_r <= head_op.y;
        end
        OP_HOLD1: begin
          h1x_r <= head_op.x;
          h1y_r <= head_op.y;
        end
        OP_EMIT_STRIP: begin
          h0x_r <= h1x_r;
          h0y_r <= h1y_r;
          h1x_r <= head_op.x;
          h1y_r <= head_op.y;
        end
        OP_EMIT_FAN: begin
          h1x_r <= head_op.x;
          h1y_r <= head_op.y;
        end
        default: begin
        end
      endcase
      if (is_emit) begin
        ax_r <= to_io(h0x_r);
        ay_r <= to_io(h0y_r);
        bx_r <= to_io(h1x_r);
        by_r <= to_io(h1y_r);
        cx_r <= to_io(head_op.x);
        cy_r <= to_io(head_op.y);
      end
    end
  end

  assign out_valid    = valid_r;
  assign out_first_x  = ax_r;
  assign out_first_y  = ay_r;
  assign out_second_x = bx_r;
  assign out_second_y = by_r;
  assign out_third_x  = cx_r;
  assign out_third_y  = cy_r;

endmodule

// ===== rtl/triangle_primitive_assembler.sv =====
// ---------------------------------------------------------------------------
// Triangle primitive assembler
// Builds triangles from a stream of begin and vertex words. Triangle, strip
// and fan modes; unknown mode drops vertices.
// ---------------------------------------------------------------------------
// One word is accepted per cycle while in_stall is low. A triangle is registered
// on the output when the op of its last vertex word leaves the queue; begin
// words and held vertices produce no output word. The front end keeps mode and
// vertex count, a two-entry op queue decouples it from the back end, which holds
// the carried vertices and a registered output word. Input stalls only when
// the queue is full, only while out_stall holds back a finished triangle.
`timescale 1ns / 1ps

module triangle_primitive_assembler import tpa_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_command,
  input  logic [1:0]       in_prim_mode,
  input  logic signed [31:0] in_vert_x,
  input  logic signed [31:0] in_vert_y,
  output logic             out_valid,
  input  logic             out_stall,
  output logic signed [31:0] out_first_x,
  output logic signed [31:0] out_first_y,
  output logic signed [31:0] out_second_x,
  output logic signed [31:0] out_second_y,
  output logic signed [31:0] out_third_x,
  output logic signed [31:0] out_third_y
);

  logic push, q_full, pop, head_valid;
  op_t  push_op, head_op;

  tpa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_prim_mode (in_prim_mode),
    .in_vert_x    (in_vert_x),
    .in_vert_y    (in_vert_y),
    .q_full       (q_full),
    .push         (push),
    .push_op      (push_op)
  );

  tpa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  tpa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head_op      (head_op),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_first_x  (out_first_x),
    .out_first_y  (out_first_y),
    .out_second_x (out_second_x),
    .out_second_y (out_second_y),
    .out_third_x  (out_third_x),
    .out_third_y  (out_third_y)
  );

endmodule

// ===== rtl/tpa_checker.sv =====
// ---------------------------------------------------------------------------
// Triangle assembler port checker
// Port-level checks on reset, input stall and the output word, bound to the
// top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [31:0] out_first_x,
  input logic signed [31:0] out_first_y,
  input logic signed [31:0] out_second_x,
  input logic signed [31:0] out_second_y,
  input logic signed [31:0] out_third_x,
  input logic signed [31:0] out_third_y
);

  logic [191:0] out_word;

  assign out_word = {out_first_x, out_first_y, out_second_x, out_second_y,
                     out_third_x, out_third_y};

  // reset empties both the queue and the output word
  `TPA_ASSERT_NEXT(a_reset_clears, clk, 1'b0, !rst_n, !out_valid && !in_stall)

  // the queue only fills up from a word accepted the cycle before
  `TPA_ASSERT_SAME(a_stall_needs_push, clk, !rst_n, $rose(in_stall), $past(in_valid && !in_stall))

  `TPA_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && out_stall, out_valid && $stable(out_word))

endmodule

bind triangle_primitive_assembler tpa_checker u_tpa_checker (.*);

// ===== dv/tpa_triangle_check.sv =====
// ---------------------------------------------------------------------------
// Triangle assembly checker
// Watches the vertex and triangle channels of the triangle primitive
// assembler. It keeps its own mode, vertex count and held corners, queues any
// triangle an accepted word should produce, and compares every accepted
// output word field by field against the oldest queued triangle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tpa_triangle_check import tpa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               in_command,
  input  logic [1:0]         in_prim_mode,
  input  logic signed [31:0] in_vert_x,
  input  logic signed [31:0] in_vert_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_first_x,
  input  logic signed [31:0] out_first_y,
  input  logic signed [31:0] out_second_x,
  input  logic signed [31:0] out_second_y,
  input  logic signed [31:0] out_third_x,
  input  logic signed [31:0] out_third_y,
  output int                 fail_count,
  output int                 pending_count,
  output int                 tri_count
);

  typedef struct {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] third_x;
    logic signed [31:0] third_y;
  } triangle_t;

  triangle_t triangle_q[$];
  mode_t     asm_mode;
  count_t    held_cnt;
  coord_t    held_x[3];
  coord_t    held_y[3];
  int        n_fail = 0;
  int        n_tri = 0;

  function automatic coord_t narrow_coord(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return w[COORD_WIDTH-1:0];
  endfunction

  function automatic logic signed [31:0] widen_coord(coord_t c);
    logic signed [63:0] w;
    w = c;
    return w[31:0];
  endfunction

  function automatic triangle_t make_triangle(coord_t ax, coord_t ay, coord_t bx,
                                              coord_t by, coord_t cx, coord_t cy);
    triangle_t t;
    t.first_x  = widen_coord(ax);
    t.first_y  = widen_coord(ay);
    t.second_x = widen_coord(bx);
    t.second_y = widen_coord(by);
    t.third_x  = widen_coord(cx);
    t.third_y  = widen_coord(cy);
    return t;
  endfunction

  task automatic assemble_word(input logic cmd, input logic [1:0] mode_bits,
                               input logic signed [31:0] vx,
                               input logic signed [31:0] vy);
    coord_t cx;
    coord_t cy;
    cx = narrow_coord(vx);
    cy = narrow_coord(vy);
    if (cmd == CMD_BEGIN) begin
      asm_mode = mode_t'(mode_bits);
      held_cnt = 0;
    end else if (asm_mode == MODE_STRIP || asm_mode == MODE_FAN) begin
      if (held_cnt < 2) begin
        held_x[held_cnt] = cx;
        held_y[held_cnt] = cy;
        held_cnt++;
      end else begin
        triangle_q.push_back(make_triangle(held_x[0], held_y[0], held_x[1],
                                           held_y[1], cx, cy));
        if (asm_mode == MODE_STRIP) begin
          held_x[0] = held_x[1];
          held_y[0] = held_y[1];
        end
        held_x[1] = cx;
        held_y[1] = cy;
      end
    end else if (asm_mode == MODE_TRIANGLES) begin
      held_x[held_cnt] = cx;
      held_y[held_cnt] = cy;
      if (held_cnt == 2) begin
        triangle_q.push_back(make_triangle(held_x[0], held_y[0], held_x[1],
                                           held_y[1], held_x[2], held_y[2]));
        held_cnt = 0;
      end else begin
        held_cnt++;
      end
    end
  endtask

  function automatic int field_bad(string name, logic signed [31:0] want,
                                   logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)",
               $time, name, want, want, got, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_triangle();
    triangle_t want;
    int bad;
    if (triangle_q.size() == 0) begin
      $display("%0t: unexpected triangle, expected none, actual (%0d,%0d) (%0d,%0d) (%0d,%0d)",
               $time, out_first_x, out_first_y, out_second_x, out_second_y,
               out_third_x, out_third_y);
      n_fail++;
    end else begin
      want = triangle_q.pop_front();
      bad = field_bad("first_x", want.first_x, out_first_x)
          + field_bad("first_y", want.first_y, out_first_y)
          + field_bad("second_x", want.second_x, out_second_x)
          + field_bad("second_y", want.second_y, out_second_y)
          + field_bad("third_x", want.third_x, out_third_x)
          + field_bad("third_y", want.third_y, out_third_y);
      if (bad != 0) n_fail++;
    end
    n_tri++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      asm_mode = MODE_UNKNOWN;
      held_cnt = 0;
      triangle_q.delete();
    end else begin
      if (out_valid && !out_stall) check_triangle();
      if (in_valid && !in_stall)
        assemble_word(in_command, in_prim_mode, in_vert_x, in_vert_y);
    end
    fail_count <= n_fail;
    pending_count <= triangle_q.size();
    tri_count <= n_tri;
  end

endmodule

// ===== dv/tb.sv =====
// ---------------------------------------------------------------------------
// Triangle primitive assembler testbench
// Drives begin and vertex words through the assembler in all four modes,
// first a directed sequence with extreme coordinates, then random primitive
// runs with random bursts of idle and output stall. Checking is done by the
// triangle assembly checker beside the DUT and the port checker bound to it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb import tpa_pkg::*;;

  localparam int NUM_WORDS = 1250;
  localparam int QUIET_TAIL = 150;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [1:0]         in_prim_mode;
  logic signed [31:0] in_vert_x;
  logic signed [31:0] in_vert_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_first_x;
  logic signed [31:0] out_first_y;
  logic signed [31:0] out_second_x;
  logic signed [31:0] out_second_y;
  logic signed [31:0] out_third_x;
  logic signed [31:0] out_third_y;

  int fail_count;
  int pending_count;
  int tri_count;
  int words_sent;
  int begins_sent;
  bit idle_on;

  triangle_primitive_assembler DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_prim_mode(in_prim_mode), .in_vert_x(in_vert_x), .in_vert_y(in_vert_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_second_x(out_second_x), .out_second_y(out_second_y),
    .out_third_x(out_third_x), .out_third_y(out_third_y)
  );

  tpa_triangle_check check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_prim_mode(in_prim_mode), .in_vert_x(in_vert_x), .in_vert_y(in_vert_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_first_x(out_first_x), .out_first_y(out_first_y),
    .out_second_x(out_second_x), .out_second_y(out_second_y),
    .out_third_x(out_third_x), .out_third_y(out_third_y),
    .fail_count(fail_count), .pending_count(pending_count), .tri_count(tri_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("triangle_primitive_assembler test failed");
    $finish;
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic cmd, input logic [1:0] mode_bits,
                           input logic signed [31:0] vx,
                           input logic signed [31:0] vy);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_prim_mode <= mode_bits;
    in_vert_x <= vx;
    in_vert_y <= vy;
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (cmd == CMD_BEGIN) begins_sent++;
  endtask

  task automatic send_begin(input mode_t mode);
    send_word(CMD_BEGIN, mode, rand_coord(), rand_coord());
  endtask

  task automatic send_vertex(input logic signed [31:0] vx,
                             input logic signed [31:0] vy);
    send_word(CMD_VERTEX, 2'($urandom_range(0, 3)), vx, vy);
  endtask

  // stall bursts on the triangle side
  initial begin
    out_stall <= 1'b0;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (idle_on && $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int nverts;
    mode_t mode;
    words_sent = 0;
    begins_sent = 0;
    idle_on = 1'b1;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_BEGIN;
    in_prim_mode <= MODE_UNKNOWN;
    in_vert_x <= '0;
    in_vert_y <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // vertex before any begin is dropped
    send_word(CMD_VERTEX, MODE_TRIANGLES, 32'sh7fff_ffff, 32'sh8000_0000);
    send_begin(MODE_TRIANGLES);
    send_vertex(32'sh7fff_ffff, 32'sh8000_0000);
    send_vertex(32'sh8000_0000, 32'sh7fff_ffff);
    send_vertex(32'sd0, -32'sd1);
    send_begin(MODE_STRIP);
    send_vertex(32'sd1, 32'sd2);
    send_vertex(32'sd3, 32'sd4);
    send_vertex(-32'sd5, 32'sd6);
    send_vertex(32'sh7fff_ffff, -32'sd7);
    send_begin(MODE_FAN);
    send_vertex(32'sd10, 32'sd20);
    send_vertex(32'sh8000_0000, 32'sd30);
    send_vertex(32'sd40, 32'sh7fff_ffff);
    send_vertex(-32'sd1, -32'sd1);
    // begin in the middle of a triangle restarts the hold
    send_begin(MODE_TRIANGLES);
    send_vertex(32'sd100, 32'sd101);
    send_vertex(32'sd102, 32'sd103);
    send_begin(MODE_UNKNOWN);
    send_vertex(32'sd55, 32'sd66);
    send_begin(MODE_TRIANGLES);
    send_vertex(32'sd7, 32'sd8);
    send_vertex(32'sd9, 32'sd10);
    send_vertex(32'sd11, 32'sd12);

    while (words_sent < NUM_WORDS) begin
      if (words_sent > NUM_WORDS - QUIET_TAIL) idle_on = 1'b0;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:       mode = MODE_TRIANGLES;
        6, 7, 8, 9, 10, 11:     mode = MODE_STRIP;
        12, 13, 14, 15, 16, 17: mode = MODE_FAN;
        default:                mode = MODE_UNKNOWN;
      endcase
      // mostly full primitives, some cut short
      nverts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
      send_begin(mode);
      repeat (nverts) send_vertex(rand_coord(), rand_coord());
    end
    in_valid <= 1'b0;

    repeat (4) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Drove %0d words, %0d of them begins across all four modes,",
             words_sent, begins_sent);
    $display("with idle and stall bursts; %0d triangles compared.", tri_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("triangle_primitive_assembler test passed");
    end else begin
      $display("triangle_primitive_assembler test failed");
    end
    $finish;
  end

endmodule
